// File: src/stt_pkg.sv
`timescale 1ns / 1ps
package stt_pkg;

  localparam int KW_BYTES = 6;   // longest keyword
  localparam int Q_DEPTH  = 8;
  localparam int Q_AW     = 3;
  localparam int MAX_TOK  = 4;   // tokens one beat can produce

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_INT_DOT, M_FRAC, M_OP,
    M_STRING, M_LINE_COMMENT, M_BLOCK, M_BLOCK_STAR
  } scan_mode_t;

  localparam logic [5:0] K_IDENT = 6'd0,  K_INT_LIT = 6'd1, K_FLOAT_LIT = 6'd2;
  localparam logic [5:0] K_STRING_LIT = 6'd3, K_BOOL_LIT = 6'd4;
  localparam logic [5:0] K_IF = 6'd5, K_ELSE = 6'd6, K_ELIF = 6'd7, K_WHILE = 6'd8;
  localparam logic [5:0] K_FOR = 6'd9, K_TRY = 6'd10, K_CATCH = 6'd11;
  localparam logic [5:0] K_RETURN = 6'd12, K_CONST = 6'd13, K_FX = 6'd14;
  localparam logic [5:0] K_INT = 6'd15, K_FLOAT = 6'd16, K_STRING = 6'd17;
  localparam logic [5:0] K_BOOL = 6'd18, K_VOID = 6'd19, K_LIST = 6'd20;
  localparam logic [5:0] K_AND = 6'd21, K_OR = 6'd22, K_NOT = 6'd23;
  localparam logic [5:0] K_PRINT = 6'd24, K_INPUT = 6'd25;
  localparam logic [5:0] K_LPAREN = 6'd26, K_RPAREN = 6'd27, K_LBRACE = 6'd28;
  localparam logic [5:0] K_RBRACE = 6'd29, K_LBRACK = 6'd30, K_RBRACK = 6'd31;
  localparam logic [5:0] K_COMMA = 6'd32, K_DOT = 6'd33, K_SEMI = 6'd34;
  localparam logic [5:0] K_PLUS = 6'd35, K_MINUS = 6'd36, K_STAR = 6'd37;
  localparam logic [5:0] K_DIVIDE = 6'd38, K_PERCENT = 6'd39, K_ASSIGN = 6'd40;
  localparam logic [5:0] K_EQ = 6'd41, K_NE = 6'd42, K_LT = 6'd43, K_LE = 6'd44;
  localparam logic [5:0] K_GT = 6'd45, K_GE = 6'd46, K_INVALID = 6'd47;
  localparam logic [5:0] K_EOF = 6'd48;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic [15:0] column;
    logic        fin;
  } tok_t;

  typedef struct packed {
    logic [2:0]           n;
    tok_t [MAX_TOK-1:0]   tok;
  } push_t;

  typedef struct packed {
    logic [Q_AW:0] level;
    logic          room;
  } qstat_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] k;
    unique case (b)
      "(": k = K_LPAREN;  ")": k = K_RPAREN;  "{": k = K_LBRACE;
      "}": k = K_RBRACE;  "[": k = K_LBRACK;  "]": k = K_RBRACK;
      ",": k = K_COMMA;   ".": k = K_DOT;     ";": k = K_SEMI;
      "+": k = K_PLUS;    "-": k = K_MINUS;   "*": k = K_STAR;
      "%": k = K_PERCENT;
      default: k = K_IDENT;  // none
    endcase
    return k;
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] op, input logic with_eq);
    logic [5:0] k;
    unique case (op)
      "=": k = with_eq ? K_EQ : K_ASSIGN;
      "!": k = with_eq ? K_NE : K_NOT;
      "<": k = with_eq ? K_LE : K_LT;
      ">": k = with_eq ? K_GE : K_GT;
      default: k = K_DIVIDE;
    endcase
    return k;
  endfunction

  // prefix packed right-aligned so it compares straight against a literal
  function automatic logic [5:0] kw_kind(input logic [KW_BYTES-1:0][7:0] p,
                                         input logic [2:0] len, input logic long_word);
    logic [8*KW_BYTES-1:0] q;
    logic [5:0] k;
    q = '0;
    for (int i = 0; i < KW_BYTES; i++)
      if (i < int'(len)) q = {q[8*KW_BYTES-9:0], p[i]};
    unique case (q)
      48'("if"):     k = K_IF;
      48'("else"):   k = K_ELSE;
      48'("elif"):   k = K_ELIF;
      48'("while"):  k = K_WHILE;
      48'("for"):    k = K_FOR;
      48'("try"):    k = K_TRY;
      48'("catch"):  k = K_CATCH;
      48'("return"): k = K_RETURN;
      48'("const"):  k = K_CONST;
      48'("fx"):     k = K_FX;
      48'("int"):    k = K_INT;
      48'("float"):  k = K_FLOAT;
      48'("string"): k = K_STRING;
      48'("bool"):   k = K_BOOL;
      48'("void"):   k = K_VOID;
      48'("list"):   k = K_LIST;
      48'("and"):    k = K_AND;
      48'("or"):     k = K_OR;
      48'("not"):    k = K_NOT;
      48'("true"):   k = K_BOOL_LIT;
      48'("false"):  k = K_BOOL_LIT;
      48'("print"):  k = K_PRINT;
      48'("input"):  k = K_INPUT;
      default:       k = K_IDENT;
    endcase
    return long_word ? K_IDENT : k;
  endfunction

endpackage

// File: src/source_text_tokenizer.sv
`timescale 1ns / 1ps
// Streaming tokenizer: one source byte per beat, one token per output beat.
// A token caused by a byte is written into the token queue on that byte's beat, then loaded into the output register.
// Throughput: one byte per cycle while the token queue holds four or fewer entries;
// a beat can raise up to four tokens, drained at one per cycle by the output register while out_stall is low.
// Reset (synchronous, rst_n low): scanner idle, line and column 1, queue and output empty.
module source_text_tokenizer import stt_pkg::*; #(
  parameter int POSITION_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [15:0] out_token_line,
  output logic [15:0] out_token_column,
  output logic        out_is_final
);
  push_t  push;
  tok_t   head, otok;
  qstat_t qstat;
  logic   pop;

  // front stalls whenever the queue cannot take a worst-case burst
  assign in_stall = !qstat.room;

  // front: classifies bytes, keeps positions, forms tokens
  stt_scanner #(
    .POSITION_BITS  (POSITION_BITS)
  ) u_scan (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_byte_present (in_byte_present),
    .in_end_of_source(in_end_of_source),
    .push            (push)
  );

  // queue decouples token bursts from the output side
  stt_tok_queue u_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (qstat)
  );

  // back: output register, one token a beat
  stt_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .stat     (qstat),
    .pop      (pop),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_tok  (otok)
  );

  assign out_token_kind   = otok.kind;
  assign out_token_start  = otok.start;
  assign out_token_length = otok.length;
  assign out_token_line   = otok.line;
  assign out_token_column = otok.column;
  assign out_is_final     = otok.fin;

  // the end flag only ever rides on the end token
  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_final) |-> (out_token_kind == K_EOF))
    else $error("final flag on a non-end token");

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.level <= (Q_AW+1)'(Q_DEPTH))
    else $error("token queue overflow");

  // tokens are only pushed on an accepted input beat
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 3'd0) |-> (in_valid && !in_stall))
    else $error("push without accepted beat");

  // an end-of-source beat always yields at least the end token
  a_eof_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_end_of_source) |-> (push.n != 3'd0))
    else $error("end of source produced no token");

endmodule

// File: src/stt_scanner.sv
`timescale 1ns / 1ps
module stt_scanner import stt_pkg::*; #(
  parameter int POSITION_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_byte_present,
  input  logic       in_end_of_source,
  output push_t      push
);
  localparam int PW = POSITION_BITS;
  localparam int CW = $clog2(KW_BYTES + 2);

  typedef struct packed {
    logic [PW-1:0] bo;
    logic [PW-1:0] ln;
    logic [PW-1:0] col;
  } pos_t;

  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } flush_t;

  localparam pos_t POS_RST = '{bo: '0, ln: PW'(1), col: PW'(1)};

  scan_mode_t                 mode_r, mode_nxt;
  logic [7:0]                 pend_r, pend_nxt;
  logic [KW_BYTES-1:0][7:0]   pre_r, pre_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  pos_t                       pos_r, pos_nxt;
  logic [PW-1:0]              so_r, so_nxt, sc_r, sc_nxt;
  push_t                      push_c;
  logic                       acc;

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] x);
    return (x != '1) ? x + PW'(1) : x;
  endfunction

  function automatic logic [15:0] clip(input logic [PW-1:0] x);
    logic [PW+15:0] w;
    w = {16'b0, x};
    return (w > (PW+16)'(65535)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic tok_t mk(input logic [5:0] k, input logic [PW-1:0] s,
                              input logic [PW-1:0] e, input logic [PW-1:0] c,
                              input logic [PW-1:0] l, input logic f);
    tok_t t;
    t.kind   = k;
    t.start  = clip(s);
    t.length = clip(e > s ? e - s : '0);
    t.line   = clip(l);
    t.column = clip(c);
    t.fin    = f;
    return t;
  endfunction

  function automatic pos_t consume(input pos_t p, input logic [7:0] b);
    pos_t r;
    r.bo = sat_inc(p.bo);
    if (b == "\n") begin
      r.ln  = sat_inc(p.ln);
      r.col = PW'(1);
    end else begin
      r.ln  = p.ln;
      r.col = sat_inc(p.col);
    end
    return r;
  endfunction

  function automatic flush_t do_flush(input logic at_end, input scan_mode_t m,
                                      input logic [7:0] op,
                                      input logic [KW_BYTES-1:0][7:0] p,
                                      input logic [CW-1:0] cnt, input logic [PW-1:0] so,
                                      input logic [PW-1:0] sc, input pos_t ps);
    flush_t f;
    logic [PW-1:0] dot_at, dot_col;
    f = '0;
    dot_at  = (ps.bo != '0) ? ps.bo - PW'(1) : '0;
    dot_col = (ps.col > PW'(1)) ? ps.col - PW'(1) : PW'(1);
    unique case (m)
      M_IDENT: begin
        f.n  = 2'd1;
        f.t0 = mk(kw_kind(p, cnt[2:0], cnt > CW'(KW_BYTES)), so, ps.bo, sc, ps.ln, 1'b0);
      end
      M_INT: begin
        f.n  = 2'd1;
        f.t0 = mk(K_INT_LIT, so, ps.bo, sc, ps.ln, 1'b0);
      end
      M_FRAC: begin
        f.n  = 2'd1;
        f.t0 = mk(K_FLOAT_LIT, so, ps.bo, sc, ps.ln, 1'b0);
      end
      M_INT_DOT: begin
        // digits then a dot not followed by a digit: two tokens
        f.n  = 2'd2;
        f.t0 = mk(K_INT_LIT, so, dot_at, sc, ps.ln, 1'b0);
        f.t1 = mk(K_DOT, dot_at, dot_at + PW'(1), dot_col, ps.ln, 1'b0);
      end
      M_OP: begin
        f.n  = 2'd1;
        f.t0 = mk(op_kind(op, 1'b0), so, ps.bo, sc, ps.ln, 1'b0);
      end
      M_STRING: begin
        if (at_end) begin
          f.n  = 2'd1;
          f.t0 = mk(K_INVALID, so, ps.bo, sc, ps.ln, 1'b0);
        end
      end
      default: f = '0;
    endcase
    return f;
  endfunction

  assign acc = in_valid && !in_stall;

  always_comb begin
    logic       handled;
    logic [7:0] b;
    logic [5:0] k;
    flush_t     f;
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    pre_nxt  = pre_r;
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    so_nxt   = so_r;
    sc_nxt   = sc_r;
    push_c   = '0;
    handled  = 1'b0;
    b        = in_text_byte;
    k        = K_IDENT;
    f        = '0;

    if (in_byte_present) begin
      unique case (mode_nxt)
        M_IDENT: begin
          if (is_alpha(b) || is_digit(b)) begin
            if (cnt_nxt < CW'(KW_BYTES)) pre_nxt[cnt_nxt[2:0]] = b;
            if (cnt_nxt <= CW'(KW_BYTES)) cnt_nxt = cnt_nxt + CW'(1);
            pos_nxt = consume(pos_nxt, b);
            handled = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(b)) begin
            pos_nxt = consume(pos_nxt, b);
            handled = 1'b1;
          end else if (b == ".") begin
            pos_nxt  = consume(pos_nxt, b);
            mode_nxt = M_INT_DOT;
            handled  = 1'b1;
          end
        end
        M_INT_DOT, M_FRAC: begin
          if (is_digit(b)) begin
            pos_nxt  = consume(pos_nxt, b);
            mode_nxt = M_FRAC;
            handled  = 1'b1;
          end
        end
        M_OP: begin
          if (pend_nxt == "/" && b == "*") begin
            pos_nxt  = consume(pos_nxt, b);
            mode_nxt = M_BLOCK;
            handled  = 1'b1;
          end else if (pend_nxt != "/" && b == "=") begin
            pos_nxt  = consume(pos_nxt, b);
            push_c.tok[0] = mk(op_kind(pend_nxt, 1'b1), so_nxt, pos_nxt.bo, sc_nxt,
                               pos_nxt.ln, 1'b0);
            push_c.n = 3'd1;
            mode_nxt = M_IDLE;
            handled  = 1'b1;
          end
        end
        M_STRING: begin
          pos_nxt = consume(pos_nxt, b);
          if (b == "\"") begin
            push_c.tok[0] = mk(K_STRING_LIT, so_nxt, pos_nxt.bo, sc_nxt, pos_nxt.ln, 1'b0);
            push_c.n = 3'd1;
            mode_nxt = M_IDLE;
          end
          handled = 1'b1;
        end
        M_LINE_COMMENT: begin
          if (b != "\n") begin
            pos_nxt = consume(pos_nxt, b);
            handled = 1'b1;
          end else begin
            mode_nxt = M_IDLE;
          end
        end
        M_BLOCK: begin
          pos_nxt = consume(pos_nxt, b);
          if (b == "*") mode_nxt = M_BLOCK_STAR;
          handled = 1'b1;
        end
        M_BLOCK_STAR: begin
          pos_nxt = consume(pos_nxt, b);
          if (b == "/") mode_nxt = M_IDLE;
          else if (b != "*") mode_nxt = M_BLOCK;
          handled = 1'b1;
        end
        default: handled = 1'b0;
      endcase

      if (!handled) begin
        f = do_flush(1'b0, mode_nxt, pend_nxt, pre_nxt, cnt_nxt, so_nxt, sc_nxt, pos_nxt);
        if (f.n != 2'd0) push_c.tok[0] = f.t0;
        if (f.n == 2'd2) push_c.tok[1] = f.t1;
        push_c.n = {1'b0, f.n};
        mode_nxt = M_IDLE;
        // start of a new token or a blank
        if (b == " " || b == "\r" || b == "\t" || b == "\n") begin
          pos_nxt = consume(pos_nxt, b);
        end else begin
          so_nxt  = pos_nxt.bo;
          sc_nxt  = pos_nxt.col;
          pos_nxt = consume(pos_nxt, b);
          if (is_digit(b)) begin
            mode_nxt = M_INT;
          end else if (is_alpha(b)) begin
            pre_nxt[0] = b;
            cnt_nxt    = CW'(1);
            mode_nxt   = M_IDENT;
          end else if (b == "/" || b == "=" || b == "!" || b == "<" || b == ">") begin
            pend_nxt = b;
            mode_nxt = M_OP;
          end else if (b == "#") begin
            mode_nxt = M_LINE_COMMENT;
          end else if (b == "\"") begin
            mode_nxt = M_STRING;
          end else begin
            k = single_kind(b);
            if (k != K_IDENT) begin
              push_c.tok[push_c.n[1:0]] = mk(k, so_nxt, pos_nxt.bo, sc_nxt,
                                             pos_nxt.ln, 1'b0);
              push_c.n = push_c.n + 3'd1;
            end
          end
        end
      end
    end

    if (in_end_of_source) begin
      f = do_flush(1'b1, mode_nxt, pend_nxt, pre_nxt, cnt_nxt, so_nxt, sc_nxt, pos_nxt);
      if (f.n != 2'd0) begin
        push_c.tok[push_c.n[1:0]] = f.t0;
        push_c.n = push_c.n + 3'd1;
      end
      if (f.n == 2'd2) begin
        push_c.tok[push_c.n[1:0]] = f.t1;
        push_c.n = push_c.n + 3'd1;
      end
      push_c.tok[push_c.n[1:0]] = mk(K_EOF, pos_nxt.bo, pos_nxt.bo, pos_nxt.col,
                                     pos_nxt.ln, 1'b1);
      push_c.n = push_c.n + 3'd1;
      mode_nxt = M_IDLE;
      pend_nxt = '0;
      cnt_nxt  = '0;
      pos_nxt  = POS_RST;
      so_nxt   = '0;
      sc_nxt   = PW'(1);
    end
  end

  always_comb begin
    push = push_c;
    if (!acc) push.n = 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pend_r <= '0;
      cnt_r  <= '0;
      pos_r  <= POS_RST;
      so_r   <= '0;
      sc_r   <= PW'(1);
    end else if (acc) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      pos_r  <= pos_nxt;
      so_r   <= so_nxt;
      sc_r   <= sc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) pre_r <= pre_nxt;
  end

endmodule

// File: src/stt_tok_queue.sv
`timescale 1ns / 1ps
module stt_tok_queue import stt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  push,
  input  logic   pop,
  output tok_t   head,
  output qstat_t stat
);
  tok_t          ent_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   lvl_r, lvl_nxt;

  assign head      = ent_r[rp_r];
  assign stat.level = lvl_r;
  assign stat.room  = lvl_r <= (Q_AW+1)'(Q_DEPTH - MAX_TOK);
  assign lvl_nxt   = lvl_r + (Q_AW+1)'(push.n) - (Q_AW+1)'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TOK; i++)
      if (i < int'(push.n)) ent_r[wp_r + Q_AW'(i)] <= push.tok[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      wp_r  <= wp_r + Q_AW'(push.n);
      rp_r  <= rp_r + Q_AW'(pop);
      lvl_r <= lvl_nxt;
    end
  end

endmodule

// File: src/stt_out_stage.sv
`timescale 1ns / 1ps
module stt_out_stage import stt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  tok_t   head,
  input  qstat_t stat,
  output logic   pop,
  input  logic   out_stall,
  output logic   out_valid,
  output tok_t   out_tok
);
  logic vld_r;
  tok_t tok_r;

  assign pop       = (stat.level != '0) && (!vld_r || !out_stall);
  assign out_valid = vld_r;
  assign out_tok   = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (!vld_r || !out_stall) vld_r <= pop;
  end

  always_ff @(posedge clk) begin
    if (pop) tok_r <= head;
  end

endmodule
